/* rtl/key_debounce_short_long_press_unit_assert.svh */
// Assertion macros for the key debounce unit.
// Used by the port checker; depends on nothing else.
`ifndef KEY_DEBOUNCE_SHORT_LONG_PRESS_UNIT_ASSERT_SVH
`define KEY_DEBOUNCE_SHORT_LONG_PRESS_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KDSLP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kdslp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define KDSLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kdslp assertion failed");

`endif

/* rtl/kdslp_pkg.sv */
// Shared types, codes and helpers for the key debounce unit.
// No dependencies; used by every other file except kdslp_if and the assertion header.
package kdslp_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CountW   = 16;
  localparam int unsigned DebW     = 8;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegActiveLevel = 2'd0;
  localparam logic [CfgIdxW-1:0] RegDebounce    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegLongPress   = 2'd2;

  localparam logic       ActiveLevelRst = 1'b0;
  localparam logic [7:0] DebounceRst    = 8'd20;
  localparam logic [15:0] LongPressRst  = 16'd1000;

  // Event codes
  localparam logic [1:0] EvNone  = 2'd0;
  localparam logic [1:0] EvShort = 2'd1;
  localparam logic [1:0] EvLong  = 2'd2;

  // Reported state codes
  localparam logic [2:0] CodeIdle    = 3'd0;
  localparam logic [2:0] CodePressDb = 3'd1;
  localparam logic [2:0] CodeDown    = 3'd2;
  localparam logic [2:0] CodeHold    = 3'd3;
  localparam logic [2:0] CodeRelDb   = 3'd4;

  typedef enum logic [4:0] {
    StIdle    = 5'b00001,
    StPressDb = 5'b00010,
    StDown    = 5'b00100,
    StHold    = 5'b01000,
    StRelDb   = 5'b10000
  } state_e;

  typedef struct packed {
    logic              press_level;
    logic [DebW-1:0]   debounce_ticks;
    logic [CountW-1:0] long_press_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] last_event;
    logic       event_done;
    logic [2:0] machine_state;
  } result_t;

  function automatic logic [2:0] state_code(state_e st);
    logic [2:0] code;
    case (st)
      StIdle:    code = CodeIdle;
      StPressDb: code = CodePressDb;
      StDown:    code = CodeDown;
      StHold:    code = CodeHold;
      StRelDb:   code = CodeRelDb;
      default:   code = CodeIdle;
    endcase
    return code;
  endfunction

endpackage

/* rtl/kdslp_if.sv */
// Request and result channel interfaces of the key debounce unit.
// No dependencies.
interface kdslp_req_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink (input valid, input pin_level, output ready);
  modport monitor (input valid, input pin_level, input ready);
endinterface

interface kdslp_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] last_event;
  logic       event_done;
  logic [2:0] machine_state;

  modport source (output valid, output last_event, output event_done,
                  output machine_state, input ready);
  modport sink (input valid, input last_event, input event_done,
                input machine_state, output ready);
  modport monitor (input valid, input last_event, input event_done,
                   input machine_state, input ready);
endinterface

/* rtl/kdslp_cfg.sv */
// Configuration registers of the key debounce unit.
// Depends on kdslp_pkg.
module kdslp_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [kdslp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [kdslp_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output kdslp_pkg::cfg_t                 cfg_o
);

  kdslp_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        kdslp_pkg::RegActiveLevel: cfg_d.press_level = cfg_wdata_i[0];
        kdslp_pkg::RegDebounce:
          cfg_d.debounce_ticks = cfg_wdata_i[kdslp_pkg::DebW-1:0];
        kdslp_pkg::RegLongPress:
          cfg_d.long_press_ticks = cfg_wdata_i[kdslp_pkg::CountW-1:0];
        default: cfg_d = cfg_q; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_level      <= kdslp_pkg::ActiveLevelRst;
      cfg_q.debounce_ticks   <= kdslp_pkg::DebounceRst;
      cfg_q.long_press_ticks <= kdslp_pkg::LongPressRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/kdslp_fsm.sv */
// Press/release state machine with its tick counter and event latch.
// Depends on kdslp_pkg.
module kdslp_fsm (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 pin_level_i,
  input  kdslp_pkg::cfg_t      cfg_i,
  output kdslp_pkg::result_t   res_o
);

  kdslp_pkg::state_e                state_q, state_d;
  logic [kdslp_pkg::CountW-1:0]     count_q, count_d;
  logic                             was_hold_q, was_hold_d;
  logic [1:0]                       event_q, event_d;
  logic                             done;
  logic                             pressed;
  logic [kdslp_pkg::CountW-1:0]     count_inc;
  logic                             deb_reached;
  logic                             long_reached;

  assign pressed      = (pin_level_i == cfg_i.press_level);
  assign count_inc    = count_q + kdslp_pkg::CountW'(1);
  assign deb_reached  = count_inc >= kdslp_pkg::CountW'(cfg_i.debounce_ticks);
  assign long_reached = count_inc >= cfg_i.long_press_ticks;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    was_hold_d = was_hold_q;
    event_d    = event_q;
    done       = 1'b0;
    case (state_q)
      kdslp_pkg::StPressDb: begin
        if (!pressed) begin
          state_d = kdslp_pkg::StIdle;
          count_d = '0;
        end else if (deb_reached) begin
          state_d = kdslp_pkg::StDown;
          count_d = '0;
        end else begin
          count_d = count_inc;
        end
      end
      kdslp_pkg::StDown: begin
        if (!pressed) begin
          state_d    = kdslp_pkg::StRelDb;
          count_d    = '0;
          was_hold_d = 1'b0;
        end else if (long_reached) begin
          state_d = kdslp_pkg::StHold;
          count_d = '0;
        end else begin
          count_d = count_inc;
        end
      end
      kdslp_pkg::StHold: begin
        // counter stays put while holding
        if (!pressed) begin
          state_d    = kdslp_pkg::StRelDb;
          count_d    = '0;
          was_hold_d = 1'b1;
        end
      end
      kdslp_pkg::StRelDb: begin
        if (pressed) begin
          // bounce: go back where we came from, restart the count
          state_d = was_hold_q ? kdslp_pkg::StHold : kdslp_pkg::StDown;
          count_d = '0;
        end else if (deb_reached) begin
          event_d = was_hold_q ? kdslp_pkg::EvLong : kdslp_pkg::EvShort;
          state_d = kdslp_pkg::StIdle;
          count_d = '0;
          done    = 1'b1;
        end else begin
          count_d = count_inc;
        end
      end
      default: begin
        state_d = pressed ? kdslp_pkg::StPressDb : kdslp_pkg::StIdle;
        count_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= kdslp_pkg::StIdle;
      count_q    <= '0;
      was_hold_q <= 1'b0;
      event_q    <= kdslp_pkg::EvNone;
    end else if (step_i) begin
      state_q    <= state_d;
      count_q    <= count_d;
      was_hold_q <= was_hold_d;
      event_q    <= event_d;
    end
  end

  assign res_o.last_event    = event_d;
  assign res_o.event_done    = done;
  assign res_o.machine_state = kdslp_pkg::state_code(state_d);

endmodule

/* rtl/kdslp_out_buf.sv */
// Result register with a skid entry for the key debounce unit.
// Depends on kdslp_pkg.
module kdslp_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  kdslp_pkg::result_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output kdslp_pkg::result_t  out_data_o
);

  logic               out_valid_q;
  logic               skid_valid_q;
  kdslp_pkg::result_t out_data_q;
  kdslp_pkg::result_t skid_data_q;
  logic               advance;

  assign in_ready_o = !skid_valid_q;
  assign advance    = out_ready_i || !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q  <= skid_valid_q || in_valid_i;
      skid_valid_q <= 1'b0;
    end else if (in_valid_i) begin
      // output stalled: park the new result
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= skid_valid_q ? skid_data_q : in_data_i;
    end else if (in_valid_i && !skid_valid_q) begin
      skid_data_q <= in_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* rtl/key_debounce_short_long_press_unit.sv */
// Key debounce unit: one pin sample per request, one result per request
// (last event, completion pulse, state code). A request is taken every
// cycle while the result side keeps up; the state update is a single
// increment-and-compare, and its result is registered in the output buffer
// before it appears on the result channel. Two results can wait in the output
// register and its skid entry before requests are held off.
// Depends on kdslp_pkg, kdslp_if, kdslp_cfg, kdslp_fsm, kdslp_out_buf.
module key_debounce_short_long_press_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [kdslp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [kdslp_pkg::CfgDataW-1:0] cfg_wdata_i,
  kdslp_req_if.sink                      req_i,
  kdslp_res_if.source                    res_o
);

  kdslp_pkg::cfg_t    cfg;
  kdslp_pkg::result_t step_res;
  kdslp_pkg::result_t out_res;
  logic               in_ready;
  logic               step;

  assign step        = req_i.valid && in_ready;
  assign req_i.ready = in_ready;

  kdslp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  kdslp_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .pin_level_i (req_i.pin_level),
    .cfg_i       (cfg),
    .res_o       (step_res)
  );

  kdslp_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (step),
    .in_ready_o  (in_ready),
    .in_data_i   (step_res),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_data_o  (out_res)
  );

  assign res_o.last_event    = out_res.last_event;
  assign res_o.event_done    = out_res.event_done;
  assign res_o.machine_state = out_res.machine_state;

endmodule

/* rtl/kdslp_checker.sv */
// Port-level checks for the key debounce unit, bound to the top level.
// Depends on kdslp_pkg and the assertion macro header.
`include "key_debounce_short_long_press_unit_assert.svh"

module kdslp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_ready_i,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [1:0] res_event_i,
  input logic       res_done_i,
  input logic [2:0] res_state_i
);

  logic       res_done;
  logic       real_event;
  logic       res_stall;
  logic [5:0] res_data;

  assign res_done   = res_valid_i && res_done_i;
  assign real_event = (res_event_i == kdslp_pkg::EvShort) ||
                      (res_event_i == kdslp_pkg::EvLong);
  assign res_stall  = res_valid_i && !res_ready_i;
  assign res_data   = {res_event_i, res_done_i, res_state_i};

  // a completed press always lands back in idle
  `KDSLP_ASSERT_NOW(a_done_idle, clk_i, rst_ni, res_done, res_state_i == kdslp_pkg::CodeIdle)
  // a completed press always carries a real event
  `KDSLP_ASSERT_NOW(a_done_event, clk_i, rst_ni, res_done, real_event)
  // with no result waiting, requests are always taken
  `KDSLP_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !res_valid_i, req_ready_i)
  // a stalled result holds
  `KDSLP_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_stall, res_valid_i && $stable(res_data))

endmodule

bind key_debounce_short_long_press_unit kdslp_checker u_kdslp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_ready_i (req_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_event_i (res_o.last_event),
  .res_done_i  (res_o.event_done),
  .res_state_i (res_o.machine_state)
);

/* sim/tb_top.sv */
// Testbench for key_debounce_short_long_press_unit: feeds pin samples, predicts
// the debounce/press FSM per sample and checks every result field.
// Depends on kdslp_pkg, kdslp_if and the unit itself.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kdslp_pkg::*;

  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;  // not a register, must be ignored
  localparam int unsigned CycleLimit = 400_000;
  localparam int unsigned HoldOffCycles = 300;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  kdslp_req_if req_if ();
  kdslp_res_if res_if ();

  key_debounce_short_long_press_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .res_o       (res_if)
  );

  always #6 clk_i = ~clk_i;

  // Predicted key state and register copy
  logic [2:0] kst_state = CodeIdle;
  logic [15:0] tick_cnt = '0;
  logic from_hold = 1'b0;
  logic [1:0] last_ev = EvNone;
  logic cfg_active = ActiveLevelRst;
  logic [7:0] cfg_deb = DebounceRst;
  logic [15:0] cfg_long = LongPressRst;

  logic pending_levels[$];
  result_t key_results_due[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic hold_off_go = 1'b0;
  int unsigned hold_off_left = 0;
  int unsigned cycle_cnt = 0;
  int unsigned mismatches = 0;
  int unsigned samples_sent = 0;
  int unsigned results_checked = 0;
  int unsigned input_stalls = 0;
  int unsigned short_seen = 0;
  int unsigned long_seen = 0;
  int unsigned settings_run = 1;
  int unsigned queued = 0;
  int unsigned state_seen[5];

  function automatic logic count_up(logic [15:0] limit);
    tick_cnt = tick_cnt + 16'd1;
    return tick_cnt >= limit;
  endfunction

  function automatic result_t step_key(logic level);
    logic pressed;
    result_t res;
    pressed = (level == cfg_active);
    res.event_done = 1'b0;
    case (kst_state)
      CodePressDb: begin
        if (!pressed) begin
          kst_state = CodeIdle;
          tick_cnt = '0;
        end else if (count_up({8'd0, cfg_deb})) begin
          kst_state = CodeDown;
          tick_cnt = '0;
        end
      end
      CodeDown: begin
        if (!pressed) begin
          kst_state = CodeRelDb;
          tick_cnt = '0;
          from_hold = 1'b0;
        end else if (count_up(cfg_long)) begin
          kst_state = CodeHold;
          tick_cnt = '0;
        end
      end
      CodeHold: begin
        // counter stays frozen while held
        if (!pressed) begin
          kst_state = CodeRelDb;
          tick_cnt = '0;
          from_hold = 1'b1;
        end
      end
      CodeRelDb: begin
        if (pressed) begin
          kst_state = from_hold ? CodeHold : CodeDown;
          tick_cnt = '0;
        end else if (count_up({8'd0, cfg_deb})) begin
          last_ev = from_hold ? EvLong : EvShort;
          kst_state = CodeIdle;
          tick_cnt = '0;
          res.event_done = 1'b1;
        end
      end
      default: begin
        kst_state = pressed ? CodePressDb : CodeIdle;
        tick_cnt = '0;
      end
    endcase
    res.last_event = last_ev;
    res.machine_state = kst_state;
    return res;
  endfunction

  // Request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        key_results_due.push_back(step_key(req_if.pin_level));
        samples_sent++;
      end
      if (req_if.valid && !req_if.ready) input_stalls++;
      if (!req_if.valid || req_if.ready) begin
        if (pending_levels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_if.valid <= 1'b1;
          req_if.pin_level <= pending_levels.pop_front();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off of the result side, counted down on its own
  always @(posedge clk_i) begin
    if (hold_off_go) begin
      hold_off_left <= HoldOffCycles;
    end else if (hold_off_left != 0) begin
      hold_off_left <= hold_off_left - 1;
    end
  end

  // Result monitor and ready generation
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (key_results_due.size() == 0) begin
          $display("%0t: result with nothing expected: event %0d done %0b state %0d", $time,
                   res_if.last_event, res_if.event_done, res_if.machine_state);
          mismatches++;
        end else begin
          want = key_results_due.pop_front();
          results_checked++;
          if (res_if.last_event !== want.last_event) begin
            $display("%0t: last_event expected %0d, got %0d", $time, want.last_event,
                     res_if.last_event);
            mismatches++;
          end
          if (res_if.event_done !== want.event_done) begin
            $display("%0t: event_done expected %0b, got %0b", $time, want.event_done,
                     res_if.event_done);
            mismatches++;
          end
          if (res_if.machine_state !== want.machine_state) begin
            $display("%0t: machine_state expected %0d, got %0d", $time, want.machine_state,
                     res_if.machine_state);
            mismatches++;
          end
          if (want.machine_state <= CodeRelDb) state_seen[want.machine_state]++;
          if (want.event_done && want.last_event == EvShort) short_seen++;
          if (want.event_done && want.last_event == EvLong) long_seen++;
        end
      end
      if (hold_off_go || hold_off_left != 0) begin
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_levels.size() != 0 || key_results_due.size() != 0 || req_if.valid)
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      RegActiveLevel: cfg_active = data[0];
      RegDebounce:    cfg_deb = data[7:0];
      RegLongPress:   cfg_long = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic queue_run(logic pressed, int n);
    repeat (n) begin
      pending_levels.push_back(pressed ? cfg_active : ~cfg_active);
      queued++;
    end
  endtask

  // One key gesture: mostly a full press and release, sometimes with bounces,
  // now and then raw noise or a release cut short.
  task automatic queue_gesture();
    int deb;
    int lng;
    int k;
    deb = (cfg_deb == 0) ? 1 : cfg_deb;
    lng = (cfg_long == 0) ? 1 : cfg_long;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 8)) begin
        pending_levels.push_back(1'($urandom_range(1)));
        queued++;
      end
    end else begin
      queue_run(1'b0, $urandom_range(0, 3));
      if ($urandom_range(3) == 0) begin
        queue_run(1'b1, $urandom_range(1, deb));
        queue_run(1'b0, 1);
      end
      if (lng <= 200 && $urandom_range(1))
        k = deb + 1 + lng + $urandom_range(0, 6);
      else
        k = deb + 1 + $urandom_range(0, (lng <= 200) ? lng - 1 : 30);
      queue_run(1'b1, k);
      if ($urandom_range(2) == 0) begin
        queue_run(1'b0, $urandom_range(1, deb));
        queue_run(1'b1, $urandom_range(1, 3));
      end
      k = deb + $urandom_range(0, 2);
      if ($urandom_range(7) == 0) k = deb - 1;
      queue_run(1'b0, k);
    end
  endtask

  task automatic run_phase(logic [CfgDataW-1:0] act, logic [CfgDataW-1:0] deb,
                           logic [CfgDataW-1:0] lng, int unsigned send_pct,
                           int unsigned recv_pct, int unsigned budget, bit press_hard);
    wait_idle();
    cfg_write(RegActiveLevel, act);
    cfg_write(RegDebounce, deb);
    cfg_write(RegLongPress, lng);
    cfg_we_i <= 1'b0;
    settings_run++;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    queued = 0;
    while (queued < budget) queue_gesture();
    if (press_hard) begin
      // hold off the result side while requests keep coming
      hold_off_go <= 1'b1;
      @(posedge clk_i);
      hold_off_go <= 1'b0;
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    req_if.valid = 1'b0;
    req_if.pin_level = 1'b0;
    res_if.ready = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: press bounce back to idle
    pending_levels.push_back(1'b1);
    pending_levels.push_back(1'b0);
    pending_levels.push_back(1'b1);
    wait_idle();

    // Fast settings, active high; index 3 must change nothing
    cfg_write(RegActiveLevel, 16'h0001);
    cfg_write(RegDebounce, 16'h0001);
    cfg_write(RegLongPress, 16'h0002);
    cfg_write(RegSpare, 16'hFFFF);
    cfg_we_i <= 1'b0;
    settings_run++;
    // press bounce, hold, bounce in release from hold, long press,
    // then bounce in release from down and a short press
    pending_levels = {1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1,
                      1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};

    run_phase(16'h0000, 16'h0003, 16'h000A, 0, 0, 100, 1'b1);
    run_phase(16'h0001, 16'h0002, 16'h0006, 85, 0, 100, 1'b0);
    run_phase(16'h0000, 16'h0001, 16'h0001, 0, 85, 100, 1'b0);
    run_phase(16'h0001, 16'h0005, 16'h0014, 9, 9, 100, 1'b0);
    // zero limits act as one; upper data bits are dropped
    run_phase(16'hFFFE, 16'hFF00, 16'h0000, 0, 0, 40, 1'b0);
    run_phase(16'h0001, 16'h1208, 16'hFFFF, 0, 0, 80, 1'b0);
    run_phase(16'h0000, 16'h0002, 16'h0003, 0, 0, 50, 1'b0);
    wait_idle();

    $display("Checked %0d results from %0d pin samples over %0d register settings;",
             results_checked, samples_sent, settings_run);
    $display("short presses %0d, long presses %0d, states idle/db/down/hold/rel %0d/%0d/%0d/%0d/%0d,",
             short_seen, long_seen, state_seen[0], state_seen[1], state_seen[2],
             state_seen[3], state_seen[4]);
    $display("input held off %0d cycles", input_stalls);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
